// ===== design/polygon_grid_cell_binning_core_macros.svh =====
// assertion macros for the polygon grid cell binning core
// used by the top level, needs nothing else
`ifndef POLYGON_GRID_CELL_BINNING_CORE_MACROS_SVH
`define POLYGON_GRID_CELL_BINNING_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define PGCB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PGCB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pgcb_pkg.sv =====
// shared types and constants of the polygon grid cell binning core
// no dependencies
`timescale 1ns / 1ps

package pgcb_pkg;

  localparam int COORD_BITS    = 32;
  localparam int INV_BITS      = 32;
  localparam int PROD_BITS     = COORD_BITS + INV_BITS;
  localparam int PROD_SHIFT    = 32;
  localparam int ID_BITS       = 13;
  localparam int GRID_BITS     = 5;
  localparam int MAX_GRID_DEF  = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_ADDR_BITS-1:0] REG_X_LOW      = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_Y_LOW      = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_Z_LOW      = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_X_INV_CELL = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_Y_INV_CELL = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_Z_INV_CELL = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID       = 3'd6;

  localparam logic [INV_BITS-1:0]  INV_RESET  = 32'd65536;
  localparam logic [GRID_BITS-1:0] GRID_RESET = 5'd2;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic  capture;
    logic  mul_en;
    axis_t mul_axis;
    logic  scale_en;
    axis_t scale_axis;
    logic  comb1;
    logic  comb2;
    logic  update;
  } pgcb_cmd_t;

  typedef struct packed {
    logic last;
  } pgcb_status_t;

endpackage

// ===== design/pgcb_ifs.sv =====
// valid/ready channel interfaces for vertex items and cell id items
// depends on pgcb_pkg
`timescale 1ns / 1ps

interface pgcb_vtx_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pgcb_pkg::COORD_BITS-1:0] vertex_x;
  logic signed [pgcb_pkg::COORD_BITS-1:0] vertex_y;
  logic signed [pgcb_pkg::COORD_BITS-1:0] vertex_z;
  logic                                   last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  output last_vertex, input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                input last_vertex, output ready);
endinterface

interface pgcb_cell_if;
  logic                             valid;
  logic                             ready;
  logic [pgcb_pkg::ID_BITS-1:0]     cell_id;

  modport source (output valid, output cell_id, input ready);
  modport sink (input valid, input cell_id, output ready);
endinterface

// ===== design/polygon_grid_cell_binning_core.sv =====
// each accepted vertex runs through the shared 32x32 multiplier, axis by axis, then
// two id combine steps and the polygon state update; a closing vertex's cell id goes
// to the output register; the next vertex is taken only after that update
// a held result does not block the next vertex until that vertex closes a polygon
// reset: synchronous active-low rst_n restores the register defaults and opens a new
// polygon; no clearing pass
`timescale 1ns / 1ps

`include "polygon_grid_cell_binning_core_macros.svh"

module polygon_grid_cell_binning_core #(
  parameter int MAX_GRID = pgcb_pkg::MAX_GRID_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pgcb_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [pgcb_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  pgcb_vtx_if.sink                           in_vtx,
  pgcb_cell_if.source                        out_cell
);

  pgcb_pkg::pgcb_cmd_t    ctl_cmd;
  pgcb_pkg::pgcb_status_t dp_status;
  logic                   ctl_in_ready;
  logic                   ctl_out_valid;
  logic [pgcb_pkg::ID_BITS-1:0] dp_cell_id;

  pgcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_ready  (ctl_in_ready),
    .out_ready (out_cell.ready),
    .out_valid (ctl_out_valid),
    .status    (dp_status),
    .cmd       (ctl_cmd)
  );

  pgcb_dpath #(
    .MAX_GRID (MAX_GRID)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .vertex_x    (in_vtx.vertex_x),
    .vertex_y    (in_vtx.vertex_y),
    .vertex_z    (in_vtx.vertex_z),
    .last_vertex (in_vtx.last_vertex),
    .cmd         (ctl_cmd),
    .status      (dp_status),
    .cell_id     (dp_cell_id)
  );

  assign in_vtx.ready     = ctl_in_ready;
  assign out_cell.valid   = ctl_out_valid;
  assign out_cell.cell_id = dp_cell_id;

  `PGCB_ASSERT_NXT(a_accept_starts_mul, clk, rst_n, in_vtx.valid && in_vtx.ready, ctl_cmd.mul_en, "accepted item did not start the multiplier pass")
  `PGCB_ASSERT_NOW(a_no_accept_busy, clk, rst_n, in_vtx.ready, !ctl_cmd.mul_en && !ctl_cmd.scale_en && !ctl_cmd.comb1 && !ctl_cmd.comb2, "input ready while an item is in flight")
  `PGCB_ASSERT_NOW(a_result_from_last, clk, rst_n, $rose(out_cell.valid), $past(ctl_cmd.update && dp_status.last), "result raised without a closing vertex update")

endmodule

// ===== design/pgcb_ctrl.sv =====
// controller: sequences the shared multiplier over the axes, the id combine
// and the polygon state update; depends on pgcb_pkg
`timescale 1ns / 1ps

module pgcb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  input  pgcb_pkg::pgcb_status_t status,
  output pgcb_pkg::pgcb_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_COMB = 5'b01000,
    ST_UPD  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  scale_vld_r, scale_vld_nxt;
  pgcb_pkg::axis_t       scale_axis_r, scale_axis_nxt;
  logic                  out_valid_r, out_valid_nxt;
  pgcb_pkg::axis_t       mul_axis;
  logic                  accept;
  logic                  upd_go;

  // z first so that y and z are ready for the first combine step
  always_comb begin
    case (cnt_r)
      2'd0:    mul_axis = pgcb_pkg::AXIS_Z;
      2'd1:    mul_axis = pgcb_pkg::AXIS_Y;
      default: mul_axis = pgcb_pkg::AXIS_X;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // a closing vertex waits while the previous result is still held
  assign upd_go    = (state_r == ST_UPD) && (!status.last || !out_valid_r || out_ready);

  always_comb begin
    cmd.capture    = accept;
    cmd.mul_en     = (state_r == ST_MUL);
    cmd.mul_axis   = mul_axis;
    cmd.scale_en   = scale_vld_r;
    cmd.scale_axis = scale_axis_r;
    cmd.comb1      = (state_r == ST_FIN);
    cmd.comb2      = (state_r == ST_COMB);
    cmd.update     = upd_go;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    scale_vld_nxt  = (state_r == ST_MUL);
    scale_axis_nxt = mul_axis;
    out_valid_nxt  = (upd_go && status.last) || (out_valid_r && !out_ready);
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = 2'd0;
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_COMB;
      end
      ST_COMB: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= 2'd0;
      scale_vld_r  <= 1'b0;
      scale_axis_r <= pgcb_pkg::AXIS_X;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      scale_vld_r  <= scale_vld_nxt;
      scale_axis_r <= scale_axis_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

// ===== design/pgcb_dpath.sv =====
// datapath: configuration registers, axis distance, shared 32x32 multiplier,
// clamp, id combine, polygon state and result register; depends on pgcb_pkg
`timescale 1ns / 1ps

module pgcb_dpath #(
  parameter int MAX_GRID = pgcb_pkg::MAX_GRID_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pgcb_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
  input  logic [pgcb_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic signed [pgcb_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [pgcb_pkg::COORD_BITS-1:0] vertex_y,
  input  logic signed [pgcb_pkg::COORD_BITS-1:0] vertex_z,
  input  logic                                   last_vertex,
  input  pgcb_pkg::pgcb_cmd_t                    cmd,
  output pgcb_pkg::pgcb_status_t                 status,
  output logic [pgcb_pkg::ID_BITS-1:0]           cell_id
);

  localparam int CB  = pgcb_pkg::COORD_BITS;
  localparam int IB  = pgcb_pkg::INV_BITS;
  localparam int PW  = pgcb_pkg::PROD_BITS;
  localparam int SH  = pgcb_pkg::PROD_SHIFT;
  localparam int QW  = PW - SH + 1;
  localparam int IDB = pgcb_pkg::ID_BITS;
  localparam int GB  = pgcb_pkg::GRID_BITS;
  localparam int NW  = $clog2(MAX_GRID + 1);
  localparam int IW  = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;

  function automatic logic [CB:0] abs_diff(input logic [CB-1:0] c, input logic [CB-1:0] l);
    logic [CB:0] d_pos;
    logic [CB:0] d_neg;
    d_pos = {c[CB-1], c} - {l[CB-1], l};
    d_neg = {l[CB-1], l} - {c[CB-1], c};
    return d_pos[CB] ? d_neg : d_pos;
  endfunction

  logic [CB-1:0]  low_r [3];
  logic [IB-1:0]  inv_r [3];
  logic [GB-1:0]  grid_r;
  logic [CB:0]    mag_r [3];
  logic           last_r;
  logic [PW-1:0]  prod_r;
  logic           hi_r;
  logic [IW-1:0]  idx_r [3];
  logic [IDB-1:0] t_r;
  logic [IDB-1:0] id_r;
  logic [IDB-1:0] first_cell_r;
  logic           spans_r;
  logic           at_first_r;
  logic [IDB-1:0] cell_id_r;

  logic [NW-1:0]  n_eff;
  logic [GB:0]    grid_ext;
  logic [CB:0]    mag_sel;
  logic [QW-1:0]  q;
  logic [IW-1:0]  q_clamp;
  logic [IDB-1:0] f_first;
  logic           f_spans;

  // zero cells counts as one, anything above the limit saturates
  assign grid_ext = {1'b0, grid_r};
  always_comb begin
    if (grid_r == '0) begin
      n_eff = NW'(1);
    end else if (grid_ext > (GB + 1)'(MAX_GRID)) begin
      n_eff = NW'(MAX_GRID);
    end else begin
      n_eff = NW'(grid_ext);
    end
  end

  assign mag_sel = mag_r[cmd.mul_axis];

  // integer part of |d| * inv / 2^32; the upper magnitude bit adds a whole inv
  always_comb begin
    q = {1'b0, prod_r[PW-1:SH]};
    if (hi_r) begin
      q = q + QW'(inv_r[cmd.scale_axis]);
    end
    if (q >= QW'(n_eff)) begin
      q_clamp = IW'(n_eff - NW'(1));
    end else begin
      q_clamp = IW'(q);
    end
  end

  assign f_first = at_first_r ? id_r : first_cell_r;
  assign f_spans = at_first_r ? 1'b0 : (spans_r || (id_r != first_cell_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r[pgcb_pkg::AXIS_X] <= '0;
      low_r[pgcb_pkg::AXIS_Y] <= '0;
      low_r[pgcb_pkg::AXIS_Z] <= '0;
      inv_r[pgcb_pkg::AXIS_X] <= pgcb_pkg::INV_RESET;
      inv_r[pgcb_pkg::AXIS_Y] <= pgcb_pkg::INV_RESET;
      inv_r[pgcb_pkg::AXIS_Z] <= pgcb_pkg::INV_RESET;
      grid_r                  <= pgcb_pkg::GRID_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        pgcb_pkg::REG_X_LOW:      low_r[pgcb_pkg::AXIS_X] <= CB'(cfg_wdata);
        pgcb_pkg::REG_Y_LOW:      low_r[pgcb_pkg::AXIS_Y] <= CB'(cfg_wdata);
        pgcb_pkg::REG_Z_LOW:      low_r[pgcb_pkg::AXIS_Z] <= CB'(cfg_wdata);
        pgcb_pkg::REG_X_INV_CELL: inv_r[pgcb_pkg::AXIS_X] <= IB'(cfg_wdata);
        pgcb_pkg::REG_Y_INV_CELL: inv_r[pgcb_pkg::AXIS_Y] <= IB'(cfg_wdata);
        pgcb_pkg::REG_Z_INV_CELL: inv_r[pgcb_pkg::AXIS_Z] <= IB'(cfg_wdata);
        pgcb_pkg::REG_GRID:       grid_r <= cfg_wdata[GB-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mag_r[pgcb_pkg::AXIS_X] <= abs_diff(vertex_x, low_r[pgcb_pkg::AXIS_X]);
      mag_r[pgcb_pkg::AXIS_Y] <= abs_diff(vertex_y, low_r[pgcb_pkg::AXIS_Y]);
      mag_r[pgcb_pkg::AXIS_Z] <= abs_diff(vertex_z, low_r[pgcb_pkg::AXIS_Z]);
      last_r                  <= last_vertex;
    end
    if (cmd.mul_en) begin
      prod_r <= PW'(mag_sel[CB-1:0]) * PW'(inv_r[cmd.mul_axis]);
      hi_r   <= mag_sel[CB];
    end
    if (cmd.scale_en) begin
      idx_r[cmd.scale_axis] <= q_clamp;
    end
    // id = 1 + x + n * (y + n * z), modulo the id width
    if (cmd.comb1) begin
      t_r <= IDB'(idx_r[pgcb_pkg::AXIS_Y]) + IDB'(n_eff) * IDB'(idx_r[pgcb_pkg::AXIS_Z]);
    end
    if (cmd.comb2) begin
      id_r <= IDB'(1) + IDB'(idx_r[pgcb_pkg::AXIS_X]) + IDB'(n_eff) * t_r;
    end
    if (cmd.update && last_r) begin
      cell_id_r <= f_spans ? '0 : f_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cell_r <= '0;
      spans_r      <= 1'b0;
      at_first_r   <= 1'b1;
    end else if (cmd.update) begin
      first_cell_r <= f_first;
      spans_r      <= last_r ? 1'b0 : f_spans;
      at_first_r   <= last_r;
    end
  end

  assign status.last = last_r;
  assign cell_id     = cell_id_r;

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for polygon_grid_cell_binning_core: vertices in, cell ids out
// depends on pgcb_pkg, the channel interfaces in pgcb_ifs.sv and the core itself
// a built-in predictor checks random ids, the row table the rest; directed rows, then random
`timescale 1ns / 1ps

module testbench;

  localparam int TOTAL_VERTICES  = 1650;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 400;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_ROWS        = 18;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_t;

  typedef struct packed {
    logic [31:0]                  x;
    logic [31:0]                  y;
    logic [31:0]                  z;
    logic                         last;
    logic [pgcb_pkg::ID_BITS-1:0] id;
  } vtx_row_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [pgcb_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
  logic [pgcb_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  pgcb_vtx_if  vtx_ch ();
  pgcb_cell_if cell_ch ();

  polygon_grid_cell_binning_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_vtx    (vtx_ch),
    .out_cell  (cell_ch)
  );

  // predictor copy of the registers and the polygon state
  logic [31:0]                    low_cfg [3];
  logic [31:0]                    inv_cfg [3];
  logic [pgcb_pkg::GRID_BITS-1:0] grid_cfg;
  logic [pgcb_pkg::ID_BITS-1:0]   cur_first_id;
  logic                           cur_spans;
  logic                           cur_open;

  logic [pgcb_pkg::ID_BITS-1:0] pending_ids [$];

  // per-phase stimulus shaping
  int unsigned span_q [3];
  int unsigned cellw_q [3];

  int err_count;
  int vertices_sent;
  int polygons_closed;
  int ids_checked;
  int cfg_settings;
  int burst_left;
  bit hold_off_done;
  int idle_run;

  vtx_row_t directed_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 13'd1},
    '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 13'd8},
    '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 13'd8},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 13'd8},
    '{32'hffff_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 13'd2},
    '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 13'd3},
    '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1, 13'd5},
    '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, 13'd0},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 13'd1},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 13'd0},
    '{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 13'd0},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 13'd0},
    '{32'h0000_ffff, 32'h0000_0000, 32'h0000_0000, 1'b0, 13'd0},
    '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 13'd0},
    '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 13'd0},
    '{32'h7fff_ffff, 32'h0002_0000, 32'hffff_0000, 1'b0, 13'd0},
    '{32'h8000_0000, 32'hffff_0000, 32'h7fff_ffff, 1'b1, 13'd8},
    '{32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff, 1'b1, 13'd1}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what,
                                 input logic [pgcb_pkg::ID_BITS-1:0] exp_id,
                                 input logic [pgcb_pkg::ID_BITS-1:0] got_id);
    $display("ERROR %0t: %s, expected %0d got %0d", $realtime, what, exp_id, got_id);
    err_count++;
  endtask

  // floor(|coord - low| * inv / 2^32) clamped to n-1
  function automatic logic [4:0] axis_cell(input logic [31:0] coord, input logic [31:0] low,
                                           input logic [31:0] inv, input int unsigned n);
    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [63:0]        prod;
    logic [31:0]        q;
    diff = $signed({coord[31], coord}) - $signed({low[31], low});
    mag  = diff[32] ? 33'd0 - diff : diff;
    prod = 64'(mag[31:0]) * 64'(inv);
    q    = prod[63:32];
    if (q > n - 1) q = n - 1;
    return q[4:0];
  endfunction

  // advances the polygon state; returns 1 when the vertex closes a polygon
  function automatic bit bin_vertex(input logic [31:0] x, input logic [31:0] y,
                                    input logic [31:0] z, input logic last,
                                    output logic [pgcb_pkg::ID_BITS-1:0] id);
    int unsigned                  n;
    int unsigned                  sum;
    logic [4:0]                   cx;
    logic [4:0]                   cy;
    logic [4:0]                   cz;
    logic [pgcb_pkg::ID_BITS-1:0] vid;
    n = (grid_cfg == 0) ? 1 :
        ((grid_cfg > pgcb_pkg::MAX_GRID_DEF) ? pgcb_pkg::MAX_GRID_DEF : grid_cfg);
    cx = axis_cell(x, low_cfg[pgcb_pkg::AXIS_X], inv_cfg[pgcb_pkg::AXIS_X], n);
    cy = axis_cell(y, low_cfg[pgcb_pkg::AXIS_Y], inv_cfg[pgcb_pkg::AXIS_Y], n);
    cz = axis_cell(z, low_cfg[pgcb_pkg::AXIS_Z], inv_cfg[pgcb_pkg::AXIS_Z], n);
    sum = 1 + cx + cy * n + cz * n * n;
    vid = sum[pgcb_pkg::ID_BITS-1:0];
    if (cur_open) begin
      cur_first_id = vid;
      cur_spans    = 1'b0;
      cur_open     = 1'b0;
    end else if (vid != cur_first_id) begin
      cur_spans = 1'b1;
    end
    id = cur_spans ? '0 : cur_first_id;
    if (last) begin
      cur_open  = 1'b1;
      cur_spans = 1'b0;
    end
    return last;
  endfunction

  task automatic write_reg(input logic [pgcb_pkg::CFG_ADDR_BITS-1:0] addr,
                           input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      pgcb_pkg::REG_X_LOW:      low_cfg[pgcb_pkg::AXIS_X] = data;
      pgcb_pkg::REG_Y_LOW:      low_cfg[pgcb_pkg::AXIS_Y] = data;
      pgcb_pkg::REG_Z_LOW:      low_cfg[pgcb_pkg::AXIS_Z] = data;
      pgcb_pkg::REG_X_INV_CELL: inv_cfg[pgcb_pkg::AXIS_X] = data;
      pgcb_pkg::REG_Y_INV_CELL: inv_cfg[pgcb_pkg::AXIS_Y] = data;
      pgcb_pkg::REG_Z_INV_CELL: inv_cfg[pgcb_pkg::AXIS_Z] = data;
      pgcb_pkg::REG_GRID:       grid_cfg = data[pgcb_pkg::GRID_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic last, input logic typed,
                             input logic [pgcb_pkg::ID_BITS-1:0] typed_id);
    logic [pgcb_pkg::ID_BITS-1:0] id;
    vtx_ch.valid       <= 1'b1;
    vtx_ch.vertex_x    <= x;
    vtx_ch.vertex_y    <= y;
    vtx_ch.vertex_z    <= z;
    vtx_ch.last_vertex <= last;
    do @(posedge clk); while (vtx_ch.ready !== 1'b1);
    vertices_sent++;
    if (bin_vertex(x, y, z, last, id)) begin
      pending_ids.insert(pending_ids.size(), typed ? typed_id : id);
      polygons_closed++;
    end
  endtask

  // bursts of items with random gaps between them, or no gaps at all when dense
  task automatic pace(input bit dense);
    int gap;
    if (!dense) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          vtx_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
  endtask

  // sender pauses until every id is back and the pipeline has settled
  task automatic drain();
    vtx_ch.valid <= 1'b0;
    while (pending_ids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure_phase(input int idx);
    logic [31:0]    lows [3];
    logic [31:0]    invs [3];
    logic [4:0]     grid;
    int unsigned    n;
    int unsigned    cellw;
    grid = (idx == 0) ? 5'd16 : (idx == 1) ? 5'd0 : (idx == 2) ? 5'd31 :
           (idx == 3) ? 5'd1 : (idx == 4) ? 5'd17 : (idx == 5) ? 5'd16 :
           5'($urandom_range(1, 16));
    n = (grid == 0) ? 1 :
        ((grid > pgcb_pkg::MAX_GRID_DEF) ? pgcb_pkg::MAX_GRID_DEF : grid);
    for (int a = 0; a < 3; a++) begin
      cellw   = $urandom_range(32'h1000, 32'h10_0000);
      lows[a] = $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
      invs[a] = 32'(64'h1_0000_0000 / cellw);
      if ($urandom_range(0, 3) == 0) invs[a] = $urandom;
      case (idx)
        0: begin
          // zero reciprocal puts everything in cell 0 of each axis
          lows[a] = '0;
          invs[a] = '0;
        end
        2: begin
          lows[a] = 32'h7fff_ffff;
          invs[a] = 32'hffff_ffff;
        end
        3: begin
          lows[a] = 32'h8000_0000;
          invs[a] = $urandom;
        end
        5: begin
          lows[a] = '0;
          invs[a] = 32'h0001_0000;
          cellw   = 32'h0001_0000;
        end
        default: ;
      endcase
      cellw_q[a] = cellw;
      span_q[a]  = cellw * (n + 1);
    end
    write_reg(pgcb_pkg::REG_X_LOW, lows[0]);
    write_reg(pgcb_pkg::REG_Y_LOW, lows[1]);
    write_reg(pgcb_pkg::REG_Z_LOW, lows[2]);
    write_reg(pgcb_pkg::REG_X_INV_CELL, invs[0]);
    write_reg(pgcb_pkg::REG_Y_INV_CELL, invs[1]);
    write_reg(pgcb_pkg::REG_Z_INV_CELL, invs[2]);
    write_reg(pgcb_pkg::REG_GRID, {27'd0, grid});
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_settings++;
  endtask

  function automatic logic [31:0] pick_coord(input int a);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return low_cfg[a] - $urandom_range(0, span_q[a]);
    return low_cfg[a] + $urandom_range(0, span_q[a]);
  endfunction

  initial begin
    int          phase_idx;
    int          phase_count;
    int          nv;
    bit          cluster;
    bit          dense;
    logic [31:0] base [3];
    logic [31:0] pos [3];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    vtx_ch.valid       = 1'b0;
    vtx_ch.vertex_x    = '0;
    vtx_ch.vertex_y    = '0;
    vtx_ch.vertex_z    = '0;
    vtx_ch.last_vertex = 1'b0;
    for (int a = 0; a < 3; a++) begin
      low_cfg[a] = '0;
      inv_cfg[a] = pgcb_pkg::INV_RESET;
    end
    grid_cfg     = pgcb_pkg::GRID_RESET;
    cur_first_id = '0;
    cur_spans    = 1'b0;
    cur_open     = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at the reset register values: n = 2, unit cells at the origin
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                  directed_rows[i].last, directed_rows[i].last, directed_rows[i].id);
    end
    drain();

    phase_idx = 0;
    while (vertices_sent < TOTAL_VERTICES) begin
      configure_phase(phase_idx);
      dense = (phase_idx % 3 == 1);
      phase_count = 0;
      while (phase_count < ITEMS_PER_PHASE) begin
        nv = $urandom_range(1, 5);
        cluster = ($urandom_range(0, 9) < 5);
        for (int a = 0; a < 3; a++) base[a] = pick_coord(a);
        for (int v = 0; v < nv; v++) begin
          for (int a = 0; a < 3; a++) begin
            // clustered polygons jitter around one point so most stay in one cell
            pos[a] = cluster ? base[a] + $urandom_range(0, cellw_q[a] / 4) : pick_coord(a);
          end
          pace(dense);
          send_vertex(pos[0], pos[1], pos[2], v == nv - 1, 1'b0, '0);
          phase_count++;
        end
      end
      drain();
      phase_idx++;
    end

    $display("run covered %0d vertices in %0d polygons over %0d register settings",
             vertices_sent, polygons_closed, cfg_settings);
    $display("%0d cell ids checked, including one output hold-off of %0d cycles",
             ids_checked, HOLD_OFF_CYCLES);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: own stall pattern plus one long hold-off to back up the core
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       rx_cycle;
    cell_ch.ready = 1'b0;
    mode          = RX_OPEN;
    mode_left     = 0;
    rx_cycle      = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (!hold_off_done && vertices_sent >= HOLD_OFF_AFTER) begin
        cell_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_OPEN:    cell_ch.ready <= 1'b1;
          RX_COIN:    cell_ch.ready <= 1'($urandom_range(0, 1));
          RX_PATTERN: cell_ch.ready <= (rx_cycle % 5 != 0);
          default:    cell_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && cell_ch.valid && cell_ch.ready) begin
      if (pending_ids.size() == 0) begin
        report_mismatch("cell id with none pending", '0, cell_ch.cell_id);
      end else begin
        if (cell_ch.cell_id !== pending_ids[0]) begin
          report_mismatch("cell_id", pending_ids[0], cell_ch.cell_id);
        end
        void'(pending_ids.pop_front());
        ids_checked++;
      end
    end
  end

  // no item moving on either side for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (vtx_ch.valid && vtx_ch.ready) || (cell_ch.valid && cell_ch.ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("ERROR %0t: watchdog, no item moved for %0d cycles, %0d ids pending",
                 $realtime, idle_run, pending_ids.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
